// ----- hw/rtl/emda_pkg.sv -----
package emda_pkg;

  // Display modes.
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_MONITOR = 2'd1;
  localparam logic [1:0] MODE_DRIVE   = 2'd2;
  localparam logic [1:0] MODE_SPEED   = 2'd3;

  // Lamp states.
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_ON    = 2'd1;
  localparam logic [1:0] LAMP_ALARM = 2'd2;

  // Command codes.
  localparam logic CMD_SET_MODE = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COOLANT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RPM_LIMIT     = 2'd1;

  localparam logic [7:0]  COOLANT_LIMIT_RESET = 8'd110;
  localparam logic [15:0] RPM_LIMIT_RESET     = 16'd6000;
  localparam logic [13:0] RPM_SHOW_MAX        = 14'd9999;

  // Reciprocal of ten: (v * 6554) >> 16 is v / 10 for v below 10000.
  localparam logic [12:0] RECIP10_14 = 13'd6554;
  // Reciprocal of ten: (v * 205) >> 11 is v / 10 for v below 100.
  localparam logic [7:0]  RECIP10_7  = 8'd205;

  // Digit positions.
  localparam logic [3:0] POS_MODE   = 4'd0;
  localparam logic [3:0] POS_A_THOU = 4'd1;
  localparam logic [3:0] POS_A_HUND = 4'd2;
  localparam logic [3:0] POS_A_TENS = 4'd3;
  localparam logic [3:0] POS_A_ONES = 4'd4;
  localparam logic [3:0] POS_ZERO   = 4'd5;
  localparam logic [3:0] POS_B_THOU = 4'd6;
  localparam logic [3:0] POS_B_HUND = 4'd7;
  localparam logic [3:0] POS_B_TENS = 4'd8;
  localparam logic [3:0] POS_LAST   = 4'd9;

  // One classified sample word, as it travels from front to back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  lamp;
    logic [1:0]  a_hund;
    logic [3:0]  a_tens;
    logic [3:0]  a_ones;
    logic [13:0] b_val;
  } sample_t;

  // Seven-segment pattern of a decimal digit, bit 0 is segment a.
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    begin
      case (d)
        4'd0: s = 7'h3F;
        4'd1: s = 7'h06;
        4'd2: s = 7'h5B;
        4'd3: s = 7'h4F;
        4'd4: s = 7'h66;
        4'd5: s = 7'h6D;
        4'd6: s = 7'h7D;
        4'd7: s = 7'h07;
        4'd8: s = 7'h7F;
        4'd9: s = 7'h6F;
        default: s = 7'h00;
      endcase
      seg_of = s;
    end
  endfunction

endpackage

// ----- hw/rtl/engine_monitor_display_alarm.sv -----
// A sample accepted by the front passes the queue and the back's sample register,
// then its digit 0 is registered on the outputs. One digit word per cycle when not
// stalled, set by the single digit result register; a set-mode word makes no output.
// The front accepts words while the two-entry queue has room.
// Reset (synchronous, rst high): mode off, limits 110 and 6000, queue and outputs empty.
module engine_monitor_display_alarm
  import emda_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [1:0]  mode,
  input  logic [7:0]  air_temp,
  input  logic [7:0]  coolant_temp,
  input  logic [15:0] rpm,
  input  logic [7:0]  intake_temp,
  input  logic [7:0]  pedal,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit_index,
  output logic [6:0]  segments,
  output logic [1:0]  lamp,
  output logic        last
);

  logic    q_full;
  logic    q_not_empty;
  logic    q_push;
  logic    q_pop;
  sample_t push_word;
  sample_t pop_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Front: takes words, keeps mode and limits, classifies samples.
  emda_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .mode         (mode),
    .air_temp     (air_temp),
    .coolant_temp (coolant_temp),
    .rpm          (rpm),
    .intake_temp  (intake_temp),
    .pedal        (pedal),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_word       (push_word)
  );

  // Queue between front and back.
  emda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_word  (pop_word)
  );

  // Back: converts and sends the ten digit words.
  emda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_word      (pop_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digit_index (digit_index),
    .segments    (segments),
    .lamp        (lamp),
    .last        (last)
  );

endmodule

// ----- hw/rtl/emda_front.sv -----
module emda_front
  import emda_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  input  logic          cmd,
  input  logic [1:0]    mode,
  input  logic [7:0]    air_temp,
  input  logic [7:0]    coolant_temp,
  input  logic [15:0]   rpm,
  input  logic [7:0]    intake_temp,
  input  logic [7:0]    pedal,
  input  logic          q_full,
  output logic          q_push,
  output sample_t       q_word
);

  logic [1:0]  current_mode;
  logic [7:0]  coolant_limit;
  logic [15:0] rpm_limit;

  logic        in_accept;
  logic [7:0]  a_val;
  logic [1:0]  a_hund;
  logic [6:0]  a_rem;
  logic [14:0] a_prod;
  logic [3:0]  a_tens;
  logic [13:0] rpm_sat;

  assign in_accept = in_valid && !q_full;
  assign q_push    = in_accept && (cmd == CMD_SAMPLE);

  // Mode and limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= MODE_OFF;
      coolant_limit <= COOLANT_LIMIT_RESET;
      rpm_limit     <= RPM_LIMIT_RESET;
    end else begin
      if (in_accept && (cmd == CMD_SET_MODE)) begin
        current_mode <= mode;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_COOLANT_LIMIT) begin
          coolant_limit <= cfg_data[7:0];
        end else if (cfg_index == CFG_RPM_LIMIT) begin
          rpm_limit <= cfg_data;
        end
      end
    end
  end

  // Pick the left-hand reading for the current mode.
  always_comb begin
    case (current_mode)
      MODE_MONITOR: a_val = air_temp;
      MODE_DRIVE:   a_val = intake_temp;
      default:      a_val = pedal;
    endcase
  end

  // Split the eight-bit reading into hundreds, tens and ones.
  always_comb begin
    if (a_val >= 8'd200) begin
      a_hund = 2'd2;
      a_rem  = 7'(a_val - 8'd200);
    end else if (a_val >= 8'd100) begin
      a_hund = 2'd1;
      a_rem  = 7'(a_val - 8'd100);
    end else begin
      a_hund = 2'd0;
      a_rem  = a_val[6:0];
    end
    a_prod = 15'(a_rem) * 15'(RECIP10_7);
    a_tens = a_prod[14:11];
  end

  // The right-hand reading: coolant, or rpm held at four digits.
  always_comb begin
    if (rpm > 16'(RPM_SHOW_MAX)) begin
      rpm_sat = RPM_SHOW_MAX;
    end else begin
      rpm_sat = rpm[13:0];
    end
  end

  // Build the queue word.
  always_comb begin
    q_word.mode   = current_mode;
    q_word.a_hund = a_hund;
    q_word.a_tens = a_tens;
    q_word.a_ones = 4'(a_rem - 7'({a_tens, 3'b000}) - 7'({a_tens, 1'b0}));
    if (current_mode == MODE_MONITOR) begin
      q_word.b_val = 14'(coolant_temp);
    end else begin
      q_word.b_val = rpm_sat;
    end
    if (current_mode == MODE_OFF) begin
      q_word.lamp = LAMP_OFF;
    end else if ((coolant_temp > coolant_limit) || (rpm > rpm_limit)) begin
      q_word.lamp = LAMP_ALARM;
    end else begin
      q_word.lamp = LAMP_ON;
    end
  end

endmodule

// ----- hw/rtl/emda_queue.sv -----
module emda_queue
  import emda_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sample_t push_word,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output sample_t pop_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  sample_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_word  = mem[rd_ptr];

  // Storage of queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ----- hw/rtl/emda_back.sv -----
module emda_back
  import emda_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  sample_t    q_word,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] digit_index,
  output logic [6:0] segments,
  output logic [1:0] lamp,
  output logic       last
);

  logic        busy;
  sample_t     cur;
  logic [3:0]  idx;
  logic [2:0]  conv_cnt;
  logic [13:0] conv_val;
  logic [3:0]  bcd [4];

  logic        emit;
  logic        finishing;
  logic [26:0] prod;
  logic [9:0]  quot;
  logic [3:0]  rem;
  logic [3:0]  dval;

  assign emit      = busy && (!out_valid || !out_stall);
  assign finishing = emit && (idx == POS_LAST);
  assign q_pop     = q_not_empty && (!busy || finishing);

  // One decimal digit of the right-hand reading per cycle, least significant first.
  always_comb begin
    prod = 27'(conv_val) * 27'(RECIP10_14);
    quot = prod[25:16];
    rem  = 4'(conv_val - 14'({quot, 3'b000}) - 14'({quot, 1'b0}));
  end

  // Digit value for the current position.
  always_comb begin
    case (idx)
      POS_MODE:   dval = 4'(cur.mode);
      POS_A_THOU: dval = 4'd0;
      POS_A_HUND: dval = 4'(cur.a_hund);
      POS_A_TENS: dval = cur.a_tens;
      POS_A_ONES: dval = cur.a_ones;
      POS_ZERO:   dval = 4'd0;
      POS_B_THOU: dval = bcd[3];
      POS_B_HUND: dval = bcd[2];
      POS_B_TENS: dval = bcd[1];
      default:    dval = bcd[0];
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      conv_cnt <= '0;
    end else begin
      if (q_pop) begin
        busy     <= 1'b1;
        conv_cnt <= 3'd4;
      end else begin
        if (finishing) begin
          busy <= 1'b0;
        end
        if (conv_cnt != '0) begin
          conv_cnt <= 3'(conv_cnt - 1'b1);
        end
      end
    end
  end

  // Sample word, position and digit conversion.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_word;
      idx      <= POS_MODE;
      conv_val <= q_word.b_val;
    end else begin
      if (emit) begin
        idx <= 4'(idx + 1'b1);
      end
      if (conv_cnt != '0) begin
        conv_val <= 14'(quot);
        bcd[3]   <= rem;
        bcd[2]   <= bcd[3];
        bcd[1]   <= bcd[2];
        bcd[0]   <= bcd[1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digit_index <= idx;
      segments    <= (cur.mode == MODE_OFF) ? 7'h00 : seg_of(dval);
      lamp        <= cur.lamp;
      last        <= (idx == POS_LAST);
    end
  end

endmodule

// ----- hw/rtl/emda_checker.sv -----
module emda_checker
  import emda_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] digit_index,
  input logic [6:0] segments,
  input logic [1:0] lamp,
  input logic       last
);

  // A stalled digit word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_index) && $stable(segments))
    else $error("stalled digit word changed");

  // The last flag marks the tenth digit only.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (digit_index == POS_LAST)))
    else $error("last flag does not match digit position");

  // Within a sample the next digit follows at once with the same lamp.
  a_next_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      out_valid && (digit_index == 4'($past(digit_index) + 1'b1)) && $stable(lamp))
    else $error("digit sequence broken");

  // An unlit lamp means off mode, where every digit is blank.
  a_off_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lamp == LAMP_OFF) |-> (segments == 7'h00))
    else $error("digit lit in off mode");

endmodule

bind engine_monitor_display_alarm emda_checker u_emda_checker (.*);
